// File: hdl/pph_pkg.sv
// ----------------------------------------------------------------------------
// pph_pkg
// Shared types, codes and constants of the polar particle histogram unit.
// ----------------------------------------------------------------------------
package pph_pkg;

  localparam int BINS_X_DEF      = 64;
  localparam int BINS_Y_DEF      = 64;
  localparam int COUNT_WIDTH_DEF = 32;

  // Width of an internal bin index; holds any index up to 1023 and the bound 1024
  localparam int IDX_W      = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int ROT_STEPS  = 16;

  // Working widths of the rotation and scaling datapath
  localparam int XY_W   = 28;
  localparam int Z_W    = 33;
  localparam int DIFF_W = 33;
  localparam int PROD_W = 50;

  localparam logic [29:0] CORDIC_GAIN = 30'd652032874;

  localparam logic [1:0] OP_BIN    = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_X_ORIGIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Y_ORIGIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_X_SCALE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_SCALE  = 2'd3;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] radius;
    logic [15:0] angle;
    logic [5:0]  read_column;
    logic [5:0]  read_row;
  } in_item_t;

  typedef struct packed {
    logic [31:0] count;
    logic        in_range;
    logic [5:0]  column;
    logic [5:0]  row;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ROTATE,
    ST_OFFSET,
    ST_SCALE_X,
    ST_SCALE_Y,
    ST_INDEX,
    ST_FETCH,
    ST_UPDATE
  } ctrl_state_t;

  typedef struct packed {
    logic clear;
    logic accept;
    logic rotate;
    logic offset;
    logic scale_x;
    logic scale_y;
    logic index;
    logic update;
  } dp_cmd_t;

  typedef struct packed {
    logic in_is_bin;
    logic rot_last;
    logic clear_last;
    logic out_free;
  } dp_status_t;

  // Arctangent of 2^-i in units of 2*pi/2^32
  function automatic logic signed [Z_W-1:0] atan_step(input logic [3:0] i);
    logic signed [Z_W-1:0] v;
    case (i)
      4'd0:    v = 33'sd536870912;
      4'd1:    v = 33'sd316933405;
      4'd2:    v = 33'sd167458907;
      4'd3:    v = 33'sd85004756;
      4'd4:    v = 33'sd42667331;
      4'd5:    v = 33'sd21354465;
      4'd6:    v = 33'sd10679838;
      4'd7:    v = 33'sd5340245;
      4'd8:    v = 33'sd2670163;
      4'd9:    v = 33'sd1335086;
      4'd10:   v = 33'sd667544;
      4'd11:   v = 33'sd333772;
      4'd12:   v = 33'sd166886;
      4'd13:   v = 33'sd83443;
      4'd14:   v = 33'sd41721;
      default: v = 33'sd20860;
    endcase
    return v;
  endfunction

endpackage

// File: hdl/polar_particle_histogram_unit.sv
// ----------------------------------------------------------------------------
// polar_particle_histogram_unit
// Bins polar particles into a two-dimensional saturating count histogram.
// ----------------------------------------------------------------------------
// Usage: each request on in_item (valid/ready) is a bin, read or
// read-and-clear; each gives exactly one result on out_item (valid/ready).
// Bin requests rotate radius and angle to x,y with a 16-step CORDIC,
// subtract the grid origin, scale by bins per unit and bump the bin.
// A bin request passes through the 16 rotation steps, offset, two scaling
// multiplies on one shared multiplier, index, memory fetch and update;
// reads and unused codes pass through index, fetch and update only.
// One request is in flight at a time: the sequencer takes the next only
// in its idle state, once the last result has entered the output register.
// Reset: registers take their defaults and a clearing pass zeroes the bin
// memory, one bin a cycle, all BINS_X*BINS_Y bins (4096 by default), during
// which in_ready stays low. Configuration writes are taken at any time.
// Stall: a finished result waits in the output register; the next request
// is accepted meanwhile but its result holds until the register frees.
// ----------------------------------------------------------------------------
module polar_particle_histogram_unit #(
  parameter int BINS_X      = pph_pkg::BINS_X_DEF,
  parameter int BINS_Y      = pph_pkg::BINS_Y_DEF,
  parameter int COUNT_WIDTH = pph_pkg::COUNT_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  pph_pkg::in_item_t              in_item,
  output logic                           out_valid,
  input  logic                           out_ready,
  output pph_pkg::out_item_t             out_item,
  input  logic                           cfg_write,
  input  logic [pph_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pph_pkg::CFG_DATA_W-1:0] cfg_data
);

  // command and status between sequencer and datapath
  pph_pkg::dp_cmd_t    cmd;
  pph_pkg::dp_status_t status;

  pph_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  pph_datapath #(
    .BINS_X      (BINS_X),
    .BINS_Y      (BINS_Y),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

// File: hdl/pph_ctrl.sv
// ----------------------------------------------------------------------------
// pph_ctrl
// Sequencer of the histogram unit: clearing pass, rotation, scaling, update.
// ----------------------------------------------------------------------------
module pph_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  pph_pkg::dp_status_t status,
  output pph_pkg::dp_cmd_t    cmd
);

  pph_pkg::ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pph_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      pph_pkg::ST_CLEAR: begin
        if (status.clear_last) state_next = pph_pkg::ST_IDLE;
      end
      pph_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = status.in_is_bin ? pph_pkg::ST_ROTATE : pph_pkg::ST_INDEX;
        end
      end
      pph_pkg::ST_ROTATE: begin
        if (status.rot_last) state_next = pph_pkg::ST_OFFSET;
      end
      pph_pkg::ST_OFFSET:  state_next = pph_pkg::ST_SCALE_X;
      pph_pkg::ST_SCALE_X: state_next = pph_pkg::ST_SCALE_Y;
      pph_pkg::ST_SCALE_Y: state_next = pph_pkg::ST_INDEX;
      pph_pkg::ST_INDEX:   state_next = pph_pkg::ST_FETCH;
      pph_pkg::ST_FETCH:   state_next = pph_pkg::ST_UPDATE;
      pph_pkg::ST_UPDATE: begin
        if (status.out_free) state_next = pph_pkg::ST_IDLE;
      end
      default: state_next = pph_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready    = (state == pph_pkg::ST_IDLE);
    cmd.clear   = (state == pph_pkg::ST_CLEAR);
    cmd.accept  = (state == pph_pkg::ST_IDLE) && in_valid;
    cmd.rotate  = (state == pph_pkg::ST_ROTATE);
    cmd.offset  = (state == pph_pkg::ST_OFFSET);
    cmd.scale_x = (state == pph_pkg::ST_SCALE_X);
    cmd.scale_y = (state == pph_pkg::ST_SCALE_Y);
    cmd.index   = (state == pph_pkg::ST_INDEX);
    cmd.update  = (state == pph_pkg::ST_UPDATE) && status.out_free;
  end

endmodule

// File: hdl/pph_datapath.sv
// ----------------------------------------------------------------------------
// pph_datapath
// CORDIC rotation, grid scaling, bin memory and output register.
// ----------------------------------------------------------------------------
module pph_datapath #(
  parameter int BINS_X      = pph_pkg::BINS_X_DEF,
  parameter int BINS_Y      = pph_pkg::BINS_Y_DEF,
  parameter int COUNT_WIDTH = pph_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  pph_pkg::in_item_t                    in_item,
  input  logic                                 cfg_write,
  input  logic [pph_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [pph_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  pph_pkg::dp_cmd_t                     cmd,
  output pph_pkg::dp_status_t                  status,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output pph_pkg::out_item_t                   out_item
);

  localparam int DEPTH = BINS_X * BINS_Y;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = pph_pkg::IDX_W;
  localparam logic [IW-1:0]          BinsXW   = IW'(BINS_X);
  localparam logic [IW-1:0]          BinsYW   = IW'(BINS_Y);
  localparam logic [AW-1:0]          LastAddr = AW'(DEPTH - 1);
  localparam logic [COUNT_WIDTH-1:0] CountMax = '1;

  // configuration
  logic signed [23:0] x_origin, y_origin;
  logic [15:0]        x_scale, y_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_origin <= '0;
      y_origin <= '0;
      x_scale  <= 16'd256;
      y_scale  <= 16'd256;
    end else if (cfg_write) begin
      case (cfg_index)
        pph_pkg::REG_X_ORIGIN: x_origin <= cfg_data;
        pph_pkg::REG_Y_ORIGIN: y_origin <= cfg_data;
        pph_pkg::REG_X_SCALE:  x_scale  <= cfg_data[15:0];
        pph_pkg::REG_Y_SCALE:  y_scale  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // request capture and rotation
  logic [1:0]                        op;
  logic [5:0]                        req_col, req_row;
  logic                              flip;
  logic signed [pph_pkg::XY_W-1:0]   x, y;
  logic signed [pph_pkg::Z_W-1:0]    z;
  logic [3:0]                        step;
  logic [45:0]                       gain_prod;
  logic                              in_flip;
  logic [31:0]                       z_init;
  logic signed [pph_pkg::XY_W-1:0]   xs, ys;
  logic signed [pph_pkg::Z_W-1:0]    atan_v;

  assign gain_prod = 46'(in_item.radius) * 46'(pph_pkg::CORDIC_GAIN);
  assign in_flip   = in_item.angle[15] ^ in_item.angle[14];
  assign z_init    = {in_item.angle, 16'h0000} - (in_flip ? 32'h8000_0000 : 32'h0);
  assign xs        = x >>> step;
  assign ys        = y >>> step;
  assign atan_v    = pph_pkg::atan_step(step);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op      <= in_item.operation;
      req_col <= in_item.read_column;
      req_row <= in_item.read_row;
      flip    <= in_flip;
      x       <= {4'b0000, gain_prod[45:22]};
      y       <= '0;
      z       <= {z_init[31], z_init};
      step    <= '0;
    end else if (cmd.rotate) begin
      if (!z[pph_pkg::Z_W-1]) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - atan_v;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + atan_v;
      end
      step <= step + 4'd1;
    end
  end

  // offset and scale
  logic signed [pph_pkg::XY_W-1:0]   xn, yn;
  logic signed [pph_pkg::DIFF_W-1:0] dx, dy;
  logic signed [pph_pkg::DIFF_W-1:0] mul_a;
  logic [15:0]                       mul_s;
  logic signed [pph_pkg::PROD_W-1:0] mul_p, px, py;

  function automatic logic signed [pph_pkg::DIFF_W-1:0] DIFF_W_ext(
    input logic signed [pph_pkg::XY_W-1:0] v);
    return {{(pph_pkg::DIFF_W - pph_pkg::XY_W){v[pph_pkg::XY_W-1]}}, v};
  endfunction

  assign xn    = flip ? -x : x;
  assign yn    = flip ? -y : y;
  assign mul_a = cmd.scale_x ? dx : dy;
  assign mul_s = cmd.scale_x ? x_scale : y_scale;
  assign mul_p = mul_a * $signed({1'b0, mul_s});

  always_ff @(posedge clk) begin
    if (cmd.offset) begin
      dx <= DIFF_W_ext(xn) - $signed({x_origin[23], x_origin, 8'h00});
      dy <= DIFF_W_ext(yn) - $signed({y_origin[23], y_origin, 8'h00});
    end
    if (cmd.scale_x) px <= mul_p;
    if (cmd.scale_y) py <= mul_p;
  end

  // bin index
  logic signed [25:0] cx, cy;
  logic               bin_hit, rd_hit;
  logic [IW-1:0]      col_sel, row_sel;
  logic               hit_sel;
  logic [IW-1:0]      col_q, row_q;
  logic               hit;
  logic [2*IW-1:0]    addr_wide;
  logic [AW-1:0]      addr;

  assign cx      = px[pph_pkg::PROD_W-1:24];
  assign cy      = py[pph_pkg::PROD_W-1:24];
  assign bin_hit = !cx[25] && (cx[24:0] < 25'(BINS_X)) && !cy[25] && (cy[24:0] < 25'(BINS_Y));
  assign rd_hit  = ({5'b0, req_col} < BinsXW) && ({5'b0, req_row} < BinsYW);

  always_comb begin
    case (op)
      pph_pkg::OP_BIN: begin
        hit_sel = bin_hit;
        col_sel = bin_hit ? cx[IW-1:0] : '0;
        row_sel = bin_hit ? cy[IW-1:0] : '0;
      end
      pph_pkg::OP_READ, pph_pkg::OP_CLEAR: begin
        hit_sel = rd_hit;
        col_sel = {5'b0, req_col};
        row_sel = {5'b0, req_row};
      end
      default: begin
        hit_sel = 1'b0;
        col_sel = '0;
        row_sel = '0;
      end
    endcase
  end

  assign addr_wide = {{IW{1'b0}}, col_sel} * {{IW{1'b0}}, BinsYW} + {{IW{1'b0}}, row_sel};

  always_ff @(posedge clk) begin
    if (cmd.index) begin
      hit   <= hit_sel;
      col_q <= col_sel;
      row_q <= row_sel;
      addr  <= addr_wide[AW-1:0];
    end
  end

  // bin memory with clearing pass
  logic [COUNT_WIDTH-1:0] mem [DEPTH];
  logic [COUNT_WIDTH-1:0] rdata;
  logic [AW-1:0]          clr_addr;
  logic [COUNT_WIDTH-1:0] inc_val;
  logic                   upd_we;
  logic [COUNT_WIDTH-1:0] upd_val;

  assign inc_val = (rdata == CountMax) ? rdata : rdata + 1'b1;
  assign upd_we  = cmd.update && hit && (op == pph_pkg::OP_BIN || op == pph_pkg::OP_CLEAR);
  assign upd_val = (op == pph_pkg::OP_BIN) ? inc_val : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      mem[clr_addr] <= '0;
    end else if (upd_we) begin
      mem[addr] <= upd_val;
    end
    rdata <= mem[addr];
  end

  // output register
  logic [63:0] cnt_ext;

  assign cnt_ext = 64'((op == pph_pkg::OP_BIN) ? inc_val : rdata);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.update) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_item.count    <= hit ? cnt_ext[31:0] : 32'd0;
      out_item.in_range <= hit;
      out_item.column   <= col_q[5:0];
      out_item.row      <= row_q[5:0];
    end
  end

  assign status.in_is_bin  = (in_item.operation == pph_pkg::OP_BIN);
  assign status.rot_last   = (step == 4'(pph_pkg::ROT_STEPS - 1));
  assign status.clear_last = (clr_addr == LastAddr);
  assign status.out_free   = !out_valid || out_ready;

endmodule
